### rtl/core/lsb_pkg.sv
package lsb_pkg;

  // coordinate format
  localparam int CW    = 32;          // coordinate width, Q16.16
  localparam int FB    = 16;          // fraction bits
  localparam int TW    = CW - 1;      // thickness width
  localparam int DW    = CW + 1;      // delta / pair sum width

  // configuration
  localparam int CFG_W     = 32;
  localparam int LIM_W     = 17;
  localparam int REG_IDX_W = 1;
  localparam logic [LIM_W-1:0] LIM_ONE   = 17'd65536;
  localparam logic [LIM_W-1:0] LIM_RESET = 17'd65470;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_LENGTH_SQ_FLOOR = 1'b0,
    REG_PARALLEL_LIMIT  = 1'b1
  } reg_idx_t;

  // direction normalisation: largest magnitude lands in [2^14, 2^15)
  localparam int U_MSB = 14;
  localparam int UW    = U_MSB + 1;
  localparam int POS_W = 6;

  // internal widths
  localparam int SQW    = 2 * UW;       // product of two direction terms
  localparam int C2W    = SQW + 1;      // sum of two squares
  localparam int L2W    = SQW + 2;      // sum of three squares
  localparam int LSQ_W  = 2 * LIM_W - 1; // limit squared, at most 2^32
  localparam int PRW    = LSQ_W + L2W;
  localparam int U_SQ_SH = 32;
  localparam int SQ_W   = 64;
  localparam int ROOT_W = SQ_W / 2;
  localparam int Q_W    = 32;

  // unit vectors are Q2.30
  localparam int C_SH     = 46;
  localparam int W_SH     = 30;
  localparam int ROUND_SH = 31;

endpackage

### rtl/core/lsb_seg_if.sv
interface lsb_seg_if;
  logic                          valid;
  logic                          ready;
  logic signed [lsb_pkg::CW-1:0] start_x;
  logic signed [lsb_pkg::CW-1:0] start_y;
  logic signed [lsb_pkg::CW-1:0] start_z;
  logic signed [lsb_pkg::CW-1:0] stop_x;
  logic signed [lsb_pkg::CW-1:0] stop_y;
  logic signed [lsb_pkg::CW-1:0] stop_z;
  logic [lsb_pkg::TW-1:0]        thickness;

  modport source (
    output valid, start_x, start_y, start_z, stop_x, stop_y, stop_z, thickness,
    input  ready
  );
  modport sink (
    input  valid, start_x, start_y, start_z, stop_x, stop_y, stop_z, thickness,
    output ready
  );
endinterface

### rtl/core/lsb_box_if.sv
interface lsb_box_if;
  logic                          valid;
  logic                          ready;
  logic signed [lsb_pkg::CW-1:0] long_axis_x;
  logic signed [lsb_pkg::CW-1:0] long_axis_y;
  logic signed [lsb_pkg::CW-1:0] long_axis_z;
  logic signed [lsb_pkg::CW-1:0] side_axis_x;
  logic signed [lsb_pkg::CW-1:0] side_axis_y;
  logic signed [lsb_pkg::CW-1:0] side_axis_z;
  logic signed [lsb_pkg::CW-1:0] normal_axis_x;
  logic signed [lsb_pkg::CW-1:0] normal_axis_y;
  logic signed [lsb_pkg::CW-1:0] normal_axis_z;
  logic signed [lsb_pkg::CW-1:0] center_x;
  logic signed [lsb_pkg::CW-1:0] center_y;
  logic signed [lsb_pkg::CW-1:0] center_z;

  modport source (
    output valid, long_axis_x, long_axis_y, long_axis_z,
           side_axis_x, side_axis_y, side_axis_z,
           normal_axis_x, normal_axis_y, normal_axis_z,
           center_x, center_y, center_z,
    input  ready
  );
  modport sink (
    input  valid, long_axis_x, long_axis_y, long_axis_z,
           side_axis_x, side_axis_y, side_axis_z,
           normal_axis_x, normal_axis_y, normal_axis_z,
           center_x, center_y, center_z,
    output ready
  );
endinterface

### rtl/core/line_segment_to_box_transform.sv
// Throughput: one segment per cycle; the whole pipeline holds while the output
// register is full and not taken.
// Depth is set by the two square roots and the six dividers, one bit per stage.
// Reset clears all valid bits and sets length_sq_floor to 0, parallel_limit to 65470.
module line_segment_to_box_transform (
  input  logic                                clk,
  input  logic                                rst,
  lsb_seg_if.sink                             seg,
  lsb_box_if.source                           box,
  input  logic                                wr_en,
  input  logic [lsb_pkg::REG_IDX_W-1:0]       wr_index,
  input  logic [lsb_pkg::CFG_W-1:0]           wr_data
);

  localparam int CW     = lsb_pkg::CW;
  localparam int TW     = lsb_pkg::TW;
  localparam int DW     = lsb_pkg::DW;
  localparam int FB     = lsb_pkg::FB;
  localparam int UW     = lsb_pkg::UW;
  localparam int SQW    = lsb_pkg::SQW;
  localparam int C2W    = lsb_pkg::C2W;
  localparam int L2W    = lsb_pkg::L2W;
  localparam int LSQ_W  = lsb_pkg::LSQ_W;
  localparam int PRW    = lsb_pkg::PRW;
  localparam int SQ_W   = lsb_pkg::SQ_W;
  localparam int ROOT_W = lsb_pkg::ROOT_W;
  localparam int Q_W    = lsb_pkg::Q_W;
  localparam int POS_W  = lsb_pkg::POS_W;
  localparam int MW     = Q_W + TW;
  localparam int SUM_W  = 2 * CW + 2;

  localparam int LAT     = 76;
  localparam int COM_DLY = 73;   // stage 1 -> 74
  localparam int DOT_DLY = 71;   // stage 3 -> 74
  localparam int CW_DLY  = 33;   // stage 8 -> 41
  localparam int SGN_DLY = 33;   // stage 41 -> 74

  localparam logic [MW:0] RND = (MW + 1)'(1) << (lsb_pkg::ROUND_SH - 1);

  typedef struct packed {
    logic [2:0][CW-1:0] ctr;
    logic [2:0][CW-1:0] lng;
    logic [2:0][CW-1:0] st;
    logic [TW-1:0]      t;
  } com_t;

  typedef struct packed {
    logic [2:0][UW-1:0]  cmag;
    logic [2:0]          cneg;
    logic [2:0][C2W-1:0] wmag;
    logic [2:0]          wneg;
  } cw_t;

  typedef struct packed {
    logic [2:0] cneg;
    logic [2:0] wneg;
  } sgn_t;

  // configuration
  logic [lsb_pkg::CFG_W-1:0] length_sq_floor;
  logic [lsb_pkg::LIM_W-1:0] parallel_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      length_sq_floor <= '0;
      parallel_limit  <= lsb_pkg::LIM_RESET;
    end else if (wr_en) begin
      case (lsb_pkg::reg_idx_t'(wr_index))
        lsb_pkg::REG_LENGTH_SQ_FLOOR: begin
          length_sq_floor <= wr_data;
        end
        lsb_pkg::REG_PARALLEL_LIMIT: begin
          parallel_limit <= wr_data[lsb_pkg::LIM_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // pipeline advance and valid bits
  logic           en;
  logic [LAT:1]   vpipe;

  assign en        = !box.valid || box.ready;
  assign seg.ready = en;
  assign box.valid = vpipe[LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[LAT-1:1], seg.valid};
    end
  end

  // stage 1: deltas, midpoints, halves
  logic signed [CW-1:0] st_in [3];
  logic signed [CW-1:0] sp_in [3];
  logic signed [DW-1:0] dif   [3];
  logic signed [DW-1:0] pair  [3];
  logic [DW-1:0]        ad1   [3];
  com_t                 com1;

  assign st_in[0] = seg.start_x;
  assign st_in[1] = seg.start_y;
  assign st_in[2] = seg.start_z;
  assign sp_in[0] = seg.stop_x;
  assign sp_in[1] = seg.stop_y;
  assign sp_in[2] = seg.stop_z;

  always_comb begin
    com1.t = seg.thickness;
    for (int i = 0; i < 3; i++) begin
      dif[i]  = DW'(sp_in[i]) - DW'(st_in[i]);
      pair[i] = DW'(sp_in[i]) + DW'(st_in[i]);
      ad1[i]  = dif[i][DW-1] ? DW'(-dif[i]) : DW'(dif[i]);
      com1.ctr[i] = pair[i][DW-1:1];
      com1.lng[i] = dif[i][DW-1:1];
      com1.st[i]  = st_in[i];
    end
  end

  logic [DW-1:0] s1_ad [3];
  logic [2:0]    s1_neg;
  com_t          s1_com;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_ad[i]  <= ad1[i];
        s1_neg[i] <= dif[i][DW-1];
      end
      s1_com <= com1;
    end
  end

  // stage 2: squares and largest magnitude
  logic [DW-1:0]   mx01;
  logic [DW-1:0]   s2_mx;
  logic [2*CW-1:0] s2_sq [3];
  logic            s2_big;
  logic [DW-1:0]   s2_ad [3];
  logic [2:0]      s2_neg;

  assign mx01 = (s1_ad[0] > s1_ad[1]) ? s1_ad[0] : s1_ad[1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s2_sq[i] <= (2 * CW)'(s1_ad[i][CW-1:0]) * (2 * CW)'(s1_ad[i][CW-1:0]);
        s2_ad[i] <= s1_ad[i];
      end
      s2_big <= s1_ad[0][CW] | s1_ad[1][CW] | s1_ad[2][CW];
      s2_mx  <= (mx01 > s1_ad[2]) ? mx01 : s1_ad[2];
      s2_neg <= s1_neg;
    end
  end

  // stage 3: dot test and leading one of the largest magnitude
  logic [SUM_W-1:0] sum3;
  logic [POS_W-1:0] pos3;
  logic             s3_dot;
  logic [POS_W-1:0] s3_pos;
  logic [DW-1:0]    s3_ad [3];
  logic [2:0]       s3_neg;

  assign sum3 = SUM_W'(s2_sq[0]) + SUM_W'(s2_sq[1]) + SUM_W'(s2_sq[2]);

  always_comb begin
    pos3 = '0;
    for (int i = 0; i < DW; i++) begin
      if (s2_mx[i]) begin
        pos3 = POS_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_dot <= !s2_big && (sum3 <= SUM_W'({length_sq_floor, {FB{1'b0}}}));
      s3_pos <= pos3;
      s3_ad  <= s2_ad;
      s3_neg <= s2_neg;
    end
  end

  // stage 4: normalised direction magnitudes
  logic [UW-1:0] s4_mu [3];
  logic [2:0]    s4_neg;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (s3_pos >= POS_W'(lsb_pkg::U_MSB)) begin
          s4_mu[i] <= UW'(s3_ad[i] >> (s3_pos - POS_W'(lsb_pkg::U_MSB)));
        end else begin
          s4_mu[i] <= UW'(s3_ad[i] << (POS_W'(lsb_pkg::U_MSB) - s3_pos));
        end
      end
      s4_neg <= s3_neg;
    end
  end

  // stage 5: products of direction terms, limit squared
  logic [lsb_pkg::LIM_W-1:0] lim;
  logic [SQW-1:0]   s5_sq [3];
  logic [SQW-1:0]   s5_p01, s5_p12, s5_p02;
  logic [LSQ_W-1:0] s5_limsq;
  logic [UW-1:0]    s5_mu [3];
  logic [2:0]       s5_neg;

  assign lim = (parallel_limit > lsb_pkg::LIM_ONE) ? lsb_pkg::LIM_ONE : parallel_limit;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s5_sq[i] <= SQW'(s4_mu[i]) * SQW'(s4_mu[i]);
      end
      s5_p01   <= SQW'(s4_mu[0]) * SQW'(s4_mu[1]);
      s5_p12   <= SQW'(s4_mu[1]) * SQW'(s4_mu[2]);
      s5_p02   <= SQW'(s4_mu[0]) * SQW'(s4_mu[2]);
      s5_limsq <= LSQ_W'(lim) * LSQ_W'(lim);
      s5_mu    <= s4_mu;
      s5_neg   <= s4_neg;
    end
  end

  // stage 6: length squared and both cross-product norms
  logic [L2W-1:0]   s6_len2;
  logic [C2W-1:0]   s6_c2a, s6_c2b;
  logic [SQW-1:0]   s6_sq1, s6_p01, s6_p12, s6_p02;
  logic [LSQ_W-1:0] s6_limsq;
  logic [UW-1:0]    s6_mu [3];
  logic [2:0]       s6_neg;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_len2  <= L2W'(s5_sq[0]) + L2W'(s5_sq[1]) + L2W'(s5_sq[2]);
      s6_c2a   <= C2W'(s5_sq[0]) + C2W'(s5_sq[2]);
      s6_c2b   <= C2W'(s5_sq[2]) + C2W'(s5_sq[1]);
      s6_sq1   <= s5_sq[1];
      s6_p01   <= s5_p01;
      s6_p12   <= s5_p12;
      s6_p02   <= s5_p02;
      s6_limsq <= s5_limsq;
      s6_mu    <= s5_mu;
      s6_neg   <= s5_neg;
    end
  end

  // stage 7: limit^2 * |u|^2
  logic [PRW-1:0] s7_prod;
  logic [L2W-1:0] s7_len2;
  logic [C2W-1:0] s7_c2a, s7_c2b;
  logic [SQW-1:0] s7_sq1, s7_p01, s7_p12, s7_p02;
  logic [UW-1:0]  s7_mu [3];
  logic [2:0]     s7_neg;

  always_ff @(posedge clk) begin
    if (en) begin
      s7_prod <= PRW'(s6_limsq) * PRW'(s6_len2);
      s7_len2 <= s6_len2;
      s7_c2a  <= s6_c2a;
      s7_c2b  <= s6_c2b;
      s7_sq1  <= s6_sq1;
      s7_p01  <= s6_p01;
      s7_p12  <= s6_p12;
      s7_p02  <= s6_p02;
      s7_mu   <= s6_mu;
      s7_neg  <= s6_neg;
    end
  end

  // stage 8: choose the up vector, form c = u x up and w = c x u
  logic           alt8;
  cw_t            cw8;
  cw_t            s8_cw;
  logic [C2W-1:0] s8_c2;
  logic [L2W-1:0] s8_len2;

  always_comb begin
    alt8 = (PRW'({s7_sq1, {lsb_pkg::U_SQ_SH{1'b0}}}) > s7_prod) ||
           (s7_mu[0] == '0 && s7_mu[2] == '0);
    if (!alt8) begin
      cw8.cmag[0] = s7_mu[2];        cw8.cneg[0] = !s7_neg[2];
      cw8.cmag[1] = '0;              cw8.cneg[1] = 1'b0;
      cw8.cmag[2] = s7_mu[0];        cw8.cneg[2] = s7_neg[0];
      cw8.wmag[0] = C2W'(s7_p01);    cw8.wneg[0] = !(s7_neg[0] ^ s7_neg[1]);
      cw8.wmag[1] = s7_c2a;          cw8.wneg[1] = 1'b0;
      cw8.wmag[2] = C2W'(s7_p12);    cw8.wneg[2] = !(s7_neg[1] ^ s7_neg[2]);
    end else begin
      cw8.cmag[0] = '0;              cw8.cneg[0] = 1'b0;
      cw8.cmag[1] = s7_mu[2];        cw8.cneg[1] = s7_neg[2];
      cw8.cmag[2] = s7_mu[1];        cw8.cneg[2] = !s7_neg[1];
      cw8.wmag[0] = s7_c2b;          cw8.wneg[0] = 1'b0;
      cw8.wmag[1] = C2W'(s7_p01);    cw8.wneg[1] = !(s7_neg[1] ^ s7_neg[0]);
      cw8.wmag[2] = C2W'(s7_p02);    cw8.wneg[2] = !(s7_neg[2] ^ s7_neg[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_cw   <= cw8;
      s8_c2   <= alt8 ? s7_c2b : s7_c2a;
      s8_len2 <= s7_len2;
    end
  end

  // stage 9: square root operands
  logic [SQ_W-1:0] s9_xrc, s9_xsq;

  always_ff @(posedge clk) begin
    if (en) begin
      s9_xrc <= SQ_W'({s8_c2, {lsb_pkg::U_SQ_SH{1'b0}}});
      s9_xsq <= SQ_W'(s8_c2) * SQ_W'(s8_len2);
    end
  end

  // stages 10..41: square roots
  logic [ROOT_W-1:0] rc41, sq41;
  cw_t               cw41;

  lsb_isqrt #(.IN_W(SQ_W)) u_isqrt_c (
    .clk  (clk),
    .en   (en),
    .x    (s9_xrc),
    .root (rc41)
  );

  lsb_isqrt #(.IN_W(SQ_W)) u_isqrt_w (
    .clk  (clk),
    .en   (en),
    .x    (s9_xsq),
    .root (sq41)
  );

  lsb_delay #(.WIDTH($bits(cw_t)), .DEPTH(CW_DLY)) u_cw_dly (
    .clk (clk),
    .en  (en),
    .d   (s8_cw),
    .q   (cw41)
  );

  // stage 42: rounded dividends
  logic [SQ_W-1:0]   s42_numc [3];
  logic [SQ_W-1:0]   s42_numw [3];
  logic [ROOT_W-1:0] s42_rc, s42_sq;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s42_numc[i] <= (SQ_W'(cw41.cmag[i]) << lsb_pkg::C_SH) + SQ_W'(rc41 >> 1);
        s42_numw[i] <= (SQ_W'(cw41.wmag[i]) << lsb_pkg::W_SH) + SQ_W'(sq41 >> 1);
      end
      s42_rc <= rc41;
      s42_sq <= sq41;
    end
  end

  sgn_t sgn41, sgn74;

  assign sgn41.cneg = cw41.cneg;
  assign sgn41.wneg = cw41.wneg;

  lsb_delay #(.WIDTH($bits(sgn_t)), .DEPTH(SGN_DLY)) u_sgn_dly (
    .clk (clk),
    .en  (en),
    .d   (sgn41),
    .q   (sgn74)
  );

  // stages 43..74: unit vector division
  logic [Q_W-1:0] qc [3];
  logic [Q_W-1:0] qw [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    lsb_div #(.NUM_W(SQ_W), .DEN_W(ROOT_W), .Q_W(Q_W)) u_div_c (
      .clk (clk),
      .en  (en),
      .num (s42_numc[i]),
      .den (s42_rc),
      .quo (qc[i])
    );
    lsb_div #(.NUM_W(SQ_W), .DEN_W(ROOT_W), .Q_W(Q_W)) u_div_w (
      .clk (clk),
      .en  (en),
      .num (s42_numw[i]),
      .den (s42_sq),
      .quo (qw[i])
    );
  end

  com_t com74;
  logic dot74;

  lsb_delay #(.WIDTH($bits(com_t)), .DEPTH(COM_DLY)) u_com_dly (
    .clk (clk),
    .en  (en),
    .d   (s1_com),
    .q   (com74)
  );

  lsb_delay #(.WIDTH(1), .DEPTH(DOT_DLY)) u_dot_dly (
    .clk (clk),
    .en  (en),
    .d   (s3_dot),
    .q   (dot74)
  );

  // stage 75: scale by thickness
  logic [MW-1:0] s75_pc [3];
  logic [MW-1:0] s75_pw [3];
  sgn_t          s75_sgn;
  com_t          s75_com;
  logic          s75_dot;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s75_pc[i] <= MW'(qc[i]) * MW'(com74.t);
        s75_pw[i] <= MW'(qw[i]) * MW'(com74.t);
      end
      s75_sgn <= sgn74;
      s75_com <= com74;
      s75_dot <= dot74;
    end
  end

  // stage 76: round half up on magnitudes, apply signs, output register
  logic [MW:0]   rnd_c [3];
  logic [MW:0]   rnd_w [3];
  logic [CW-1:0] nm    [3];
  logic [CW-1:0] sd    [3];
  logic [CW-1:0] hh;
  logic [CW-1:0] hsum;

  always_comb begin
    hsum = {1'b0, s75_com.t} + CW'(1);
    hh   = hsum >> 1;
    for (int i = 0; i < 3; i++) begin
      rnd_c[i] = (({1'b0, s75_pc[i]} + RND) >> lsb_pkg::ROUND_SH);
      rnd_w[i] = (({1'b0, s75_pw[i]} + RND) >> lsb_pkg::ROUND_SH);
      nm[i] = s75_sgn.cneg[i] ? -rnd_c[i][CW-1:0] : rnd_c[i][CW-1:0];
      sd[i] = s75_sgn.wneg[i] ? -rnd_w[i][CW-1:0] : rnd_w[i][CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (s75_dot) begin
        box.long_axis_x   <= hh;
        box.long_axis_y   <= '0;
        box.long_axis_z   <= '0;
        box.side_axis_x   <= '0;
        box.side_axis_y   <= hh;
        box.side_axis_z   <= '0;
        box.normal_axis_x <= '0;
        box.normal_axis_y <= '0;
        box.normal_axis_z <= hh;
        box.center_x      <= s75_com.st[0];
        box.center_y      <= s75_com.st[1];
        box.center_z      <= s75_com.st[2];
      end else begin
        box.long_axis_x   <= s75_com.lng[0];
        box.long_axis_y   <= s75_com.lng[1];
        box.long_axis_z   <= s75_com.lng[2];
        box.side_axis_x   <= sd[0];
        box.side_axis_y   <= sd[1];
        box.side_axis_z   <= sd[2];
        box.normal_axis_x <= nm[0];
        box.normal_axis_y <= nm[1];
        box.normal_axis_z <= nm[2];
        box.center_x      <= s75_com.ctr[0];
        box.center_y      <= s75_com.ctr[1];
        box.center_z      <= s75_com.ctr[2];
      end
    end
  end

  // checks
  a_rst_empty: assert property (@(posedge clk) rst |=> !box.valid)
    else $error("output valid right after reset");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    (seg.valid && seg.ready) |=> vpipe[1])
    else $error("accepted transaction missing from first stage");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vpipe))
    else $error("valid bits moved during a stall");

endmodule

### rtl/core/lsb_delay.sv
module lsb_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] tap [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      tap[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        tap[i] <= tap[i-1];
      end
    end
  end

  assign q = tap[DEPTH-1];

endmodule

### rtl/core/lsb_isqrt.sv
// floor square root, one result bit per stage
module lsb_isqrt #(
  parameter int IN_W = 64
) (
  input  logic              clk,
  input  logic              en,
  input  logic [IN_W-1:0]   x,
  output logic [IN_W/2-1:0] root
);

  localparam int RW = IN_W / 2;

  logic [IN_W-1:0] rem_q  [RW-1];
  logic [RW-1:0]   root_q [RW];

  for (genvar j = 0; j < RW; j++) begin : g_step
    localparam int B = RW - 1 - j;
    logic [IN_W-1:0] rem_in;
    logic [IN_W-1:0] trial;
    logic [RW-1:0]   root_in;
    logic            take;

    if (j == 0) begin : g_first
      assign rem_in  = x;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
    end

    // (root + 2^B)^2 - root^2; root has no bits at or below B yet
    assign trial = (IN_W'(root_in) << (B + 1)) | (IN_W'(1) << (2 * B));
    assign take  = rem_in >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        root_q[j] <= take ? (root_in | (RW'(1) << B)) : root_in;
      end
    end

    if (j < RW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[j] <= take ? (rem_in - trial) : rem_in;
        end
      end
    end
  end

  assign root = root_q[RW-1];

endmodule

### rtl/core/lsb_div.sv
// restoring divider, one quotient bit per stage; num < den * 2^Q_W
module lsb_div #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 32,
  parameter int Q_W   = 32
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quo
);

  logic [NUM_W-1:0] rem_q [Q_W-1];
  logic [DEN_W-1:0] den_q [Q_W-1];
  logic [Q_W-1:0]   q_q   [Q_W];

  for (genvar j = 0; j < Q_W; j++) begin : g_step
    localparam int K = Q_W - 1 - j;
    logic [NUM_W-1:0] rem_in;
    logic [NUM_W-1:0] trial;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   q_in;
    logic             take;

    if (j == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign den_in = den_q[j-1];
      assign q_in   = q_q[j-1];
    end

    assign trial = NUM_W'(den_in) << K;
    assign take  = rem_in >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        q_q[j] <= take ? (q_in | (Q_W'(1) << K)) : q_in;
      end
    end

    if (j < Q_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[j] <= take ? (rem_in - trial) : rem_in;
          den_q[j] <= den_in;
        end
      end
    end
  end

  assign quo = q_q[Q_W-1];

endmodule
